### rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Widths, datapath operation codes and the microcode program of the filter
// sequencer.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned GainW = FracW + 1;
  localparam int unsigned PredW = DataW + 1;
  localparam int unsigned DenW  = DataW + 2;
  localparam int unsigned NumW  = PredW + FracW + 1;
  localparam int unsigned ProdW = GainW + 1 + DenW;
  localparam int unsigned CntW  = $clog2(GainW);
  localparam int unsigned PcW   = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgProcessNoise     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMeasurementNoise = 1'b1;
  localparam logic [DataW-1:0]   ProcessNoiseRst     = DataW'(328);
  localparam logic [DataW-1:0]   MeasurementNoiseRst = DataW'(35586);
  localparam logic [GainW-1:0]   GainOne = GainW'(1) << FracW;
  localparam logic [CntW-1:0]    DivSteps = CntW'(GainW - 1);

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DENOM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN,
    OP_MUL_EST,
    OP_EST,
    OP_MUL_COV,
    OP_COV,
    OP_CLEAR,
    OP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NO_XFER,
    JC_CLEAR,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } jcond_e;

  typedef struct packed {
    uop_e           op;
    jcond_e         cond;
    logic [PcW-1:0] target;
    logic           done;
  } uword_t;

  localparam logic [PcW-1:0] PcIdle     = 4'd0;
  localparam logic [PcW-1:0] PcDenom    = 4'd1;
  localparam logic [PcW-1:0] PcDivInit  = 4'd2;
  localparam logic [PcW-1:0] PcDivStep  = 4'd3;
  localparam logic [PcW-1:0] PcGain     = 4'd4;
  localparam logic [PcW-1:0] PcMulEst   = 4'd5;
  localparam logic [PcW-1:0] PcEst      = 4'd6;
  localparam logic [PcW-1:0] PcMulCov   = 4'd7;
  localparam logic [PcW-1:0] PcCov      = 4'd8;
  localparam logic [PcW-1:0] PcClear    = 4'd9;
  localparam logic [PcW-1:0] PcEmit     = 4'd10;

  function automatic uword_t ucode_rom(logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_IDLE, cond: JC_ALWAYS, target: PcIdle, done: 1'b0};
    unique case (pc)
      PcIdle:    w = '{op: OP_IDLE,     cond: JC_NO_XFER,  target: PcIdle,    done: 1'b0};
      PcDenom:   w = '{op: OP_DENOM,    cond: JC_CLEAR,    target: PcClear,   done: 1'b0};
      PcDivInit: w = '{op: OP_DIV_INIT, cond: JC_NONE,     target: PcIdle,    done: 1'b0};
      PcDivStep: w = '{op: OP_DIV_STEP, cond: JC_DIV_MORE, target: PcDivStep, done: 1'b0};
      PcGain:    w = '{op: OP_GAIN,     cond: JC_NONE,     target: PcIdle,    done: 1'b0};
      PcMulEst:  w = '{op: OP_MUL_EST,  cond: JC_NONE,     target: PcIdle,    done: 1'b0};
      PcEst:     w = '{op: OP_EST,      cond: JC_NONE,     target: PcIdle,    done: 1'b0};
      PcMulCov:  w = '{op: OP_MUL_COV,  cond: JC_NONE,     target: PcIdle,    done: 1'b0};
      PcCov:     w = '{op: OP_COV,      cond: JC_ALWAYS,   target: PcEmit,    done: 1'b0};
      PcClear:   w = '{op: OP_CLEAR,    cond: JC_NONE,     target: PcIdle,    done: 1'b0};
      PcEmit:    w = '{op: OP_EMIT,     cond: JC_OUT_BUSY, target: PcEmit,    done: 1'b1};
      default:   w = '{op: OP_IDLE,     cond: JC_ALWAYS,   target: PcIdle,    done: 1'b0};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional Kalman filter in signed Q16.16, run by a microcoded
// sequencer over a shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// An update transfer runs the denominator, the gain division, the estimate
// and covariance updates and the emit step; a clear transfer zeroes the
// estimate, covariance and gain and then emits. The update time is set by
// the gain division, which resolves one quotient bit per cycle, and by the
// two passes through the one shared multiplier. A finished result waits in
// an output register, so the next input is taken while it is still pending.
module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    command_i,
  input  logic signed [DataW-1:0] measurement_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] estimate_o,
  output logic        [GainW-1:0] gain_o,
  input  logic                    cfg_we_i,
  input  logic      [CfgIdxW-1:0] cfg_index_i,
  input  logic        [DataW-1:0] cfg_data_i
);

  logic [PcW-1:0] pc_q, pc_d;
  uword_t uw;

  logic [DataW-1:0] q_noise_q, r_noise_q;
  logic signed [DataW-1:0] est_q, est_d;
  logic [DataW-1:0] cov_q, cov_d;
  logic cmd_q, cmd_d;
  logic signed [DataW-1:0] meas_q, meas_d;
  logic [PredW-1:0] pred_q, pred_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [GainW-1:0] num_q, num_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [GainW-1:0] gain_q, gain_d;
  logic signed [PredW-1:0] innov_q, innov_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_est_q, out_est_d;
  logic [GainW-1:0] out_gain_q, out_gain_d;

  logic in_xfer;
  logic out_busy;
  logic jump;
  logic [NumW-1:0] num_init;
  logic [DenW:0] rem_sh, div_diff;
  logic div_ge;
  logic [GainW-1:0] mul_a;
  logic signed [DenW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [ProdW-1:0] rnd;
  logic signed [ProdW-FracW-1:0] corr;
  logic signed [ProdW-FracW-1:0] est_sum;

  assign uw = ucode_rom(pc_q);
  assign in_stall_o = (pc_q != PcIdle);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    unique case (uw.cond)
      JC_NONE:     jump = 1'b0;
      JC_ALWAYS:   jump = 1'b1;
      JC_NO_XFER:  jump = !in_xfer;
      JC_CLEAR:    jump = cmd_q;
      JC_DIV_MORE: jump = (cnt_q != '0);
      JC_OUT_BUSY: jump = out_busy;
      default:     jump = 1'b1;
    endcase
    if (jump) begin
      pc_d = uw.target;
    end else if (uw.done) begin
      pc_d = PcIdle;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  assign num_init = {1'b0, pred_q, FracW'(0)} + NumW'(den_q[DenW-1:1]);
  assign rem_sh   = {rem_q, num_q[GainW-1]};
  assign div_diff = rem_sh - {1'b0, den_q};
  assign div_ge   = !div_diff[DenW];

  always_comb begin
    if (uw.op == OP_MUL_COV) begin
      mul_a = GainOne - gain_q;
      mul_b = $signed({1'b0, pred_q});
    end else begin
      mul_a = gain_q;
      mul_b = DenW'(innov_q);
    end
  end

  assign mul_p   = $signed({1'b0, mul_a}) * mul_b;
  assign rnd     = prod_q + ProdW'(1 << (FracW - 1));
  assign corr    = rnd[ProdW-1:FracW];
  assign est_sum = (ProdW-FracW)'(est_q) + corr;

  always_comb begin
    est_d       = est_q;
    cov_d       = cov_q;
    cmd_d       = cmd_q;
    meas_d      = meas_q;
    pred_d      = pred_q;
    den_d       = den_q;
    rem_d       = rem_q;
    num_d       = num_q;
    cnt_d       = cnt_q;
    gain_d      = gain_q;
    innov_d     = innov_q;
    prod_d      = prod_q;
    out_est_d   = out_est_q;
    out_gain_d  = out_gain_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (uw.op)
      OP_IDLE: begin
        if (in_xfer) begin
          cmd_d  = command_i;
          meas_d = measurement_i;
          pred_d = PredW'(cov_q) + PredW'(q_noise_q);
        end
      end
      OP_DENOM: begin
        den_d = DenW'(pred_q) + DenW'(r_noise_q);
      end
      OP_DIV_INIT: begin
        rem_d = DenW'(num_init[NumW-1:GainW]);
        num_d = num_init[GainW-1:0];
        cnt_d = DivSteps;
      end
      OP_DIV_STEP: begin
        rem_d = div_ge ? div_diff[DenW-1:0] : rem_sh[DenW-1:0];
        num_d = {num_q[GainW-2:0], div_ge};
        cnt_d = cnt_q - CntW'(1);
      end
      OP_GAIN: begin
        if (den_q == '0) begin
          gain_d = '0;
        end else if (num_q > GainOne) begin
          gain_d = GainOne;
        end else begin
          gain_d = num_q;
        end
        innov_d = PredW'(meas_q) - PredW'(est_q);
      end
      OP_MUL_EST, OP_MUL_COV: begin
        prod_d = mul_p;
      end
      OP_EST: begin
        if (est_sum[ProdW-FracW-1:DataW-1] == '0 ||
            est_sum[ProdW-FracW-1:DataW-1] == '1) begin
          est_d = est_sum[DataW-1:0];
        end else if (est_sum[ProdW-FracW-1]) begin
          est_d = {1'b1, (DataW-1)'(0)};
        end else begin
          est_d = {1'b0, {(DataW-1){1'b1}}};
        end
      end
      OP_COV: begin
        if (corr[ProdW-FracW-1:DataW-1] != '0) begin
          cov_d = {1'b0, {(DataW-1){1'b1}}};
        end else begin
          cov_d = {1'b0, corr[DataW-2:0]};
        end
      end
      OP_CLEAR: begin
        est_d  = '0;
        cov_d  = '0;
        gain_d = '0;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_est_d   = est_q;
          out_gain_d  = gain_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcIdle;
      q_noise_q   <= ProcessNoiseRst;
      r_noise_q   <= MeasurementNoiseRst;
      est_q       <= '0;
      cov_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      cmd_q       <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      est_q       <= est_d;
      cov_q       <= cov_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      cmd_q       <= cmd_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgProcessNoise:     q_noise_q <= cfg_data_i;
          CfgMeasurementNoise: r_noise_q <= cfg_data_i;
          default:             q_noise_q <= q_noise_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q     <= meas_d;
    pred_q     <= pred_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    num_q      <= num_d;
    gain_q     <= gain_d;
    innov_q    <= innov_d;
    prod_q     <= prod_d;
    out_est_q  <= out_est_d;
    out_gain_q <= out_gain_d;
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;
  assign gain_o      = out_gain_q;

  a_cov_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cov_q[DataW-1])
    else $error("Kept covariance left its range.");

  a_update_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (pc_q == PcDenom))
    else $error("Accepted transfer did not start the program.");

  a_div_loops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcDivStep && cnt_q != '0) |=> (pc_q == PcDivStep))
    else $error("Division ended early.");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(pc_q) == PcEmit))
    else $error("Result appeared outside the emit step.");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcMulEst) |-> (gain_q <= GainOne))
    else $error("Gain exceeds one.");

endmodule
